// ===== src/msic_pkg.sv =====
// Shared constants, codes and types of the MIPS subset instruction core.
package msic_pkg;

  localparam int MEM_WORDS_DEF = 4096;

  localparam logic [31:0] RET_ADDR_RST = 32'h8123_456C;
  localparam logic [31:0] IN_ADDR_RST  = 32'hFFFF_0004;
  localparam logic [31:0] OUT_ADDR_RST = 32'hFFFF_000C;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  // request kinds
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_WREG = 2'd1;
  localparam logic [1:0] REQ_EXEC = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_RET = 2'd0;
  localparam logic [1:0] CFG_IN  = 2'd1;
  localparam logic [1:0] CFG_OUT = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OPCODE  = 3'd1;
  localparam logic [2:0] ERR_ALIGN   = 3'd2;
  localparam logic [2:0] ERR_RANGE   = 3'd3;
  localparam logic [2:0] ERR_DIVZERO = 3'd4;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;

  // R-type function codes
  localparam logic [5:0] F_ADD   = 6'h20;
  localparam logic [5:0] F_SUB   = 6'h22;
  localparam logic [5:0] F_MULT  = 6'h18;
  localparam logic [5:0] F_MULTU = 6'h19;
  localparam logic [5:0] F_DIV   = 6'h1a;
  localparam logic [5:0] F_DIVU  = 6'h1b;
  localparam logic [5:0] F_MFHI  = 6'h10;
  localparam logic [5:0] F_MFLO  = 6'h12;
  localparam logic [5:0] F_LIS   = 6'h14;
  localparam logic [5:0] F_SLT   = 6'h2a;
  localparam logic [5:0] F_SLTU  = 6'h2b;
  localparam logic [5:0] F_JR    = 6'h08;
  localparam logic [5:0] F_JALR  = 6'h09;

  localparam logic [4:0] REG_SP = 5'd30;
  localparam logic [4:0] REG_RA = 5'd31;

  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
    logic [31:0] r;
  } div_rsp_t;

endpackage

// ===== src/msic_div.sv =====
// Iterative 32-bit divider, one quotient bit per cycle, signed or unsigned.
module msic_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msic_pkg::div_req_t req,
  output msic_pkg::div_rsp_t rsp
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        neg_q_r, neg_r_r;
  logic        na, nb;
  logic [32:0] rem_sh, diff;

  assign na     = req.sgn & req.a[31];
  assign nb     = req.sgn & req.b[31];
  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= '0;
      quo_r   <= na ? (32'd0 - req.a) : req.a;
      dvs_r   <= nb ? (32'd0 - req.b) : req.b;
      neg_q_r <= na ^ nb;
      neg_r_r <= na;
    end else if (busy_r) begin
      rem_r <= diff[32] ? rem_sh[31:0] : diff[31:0];
      quo_r <= {quo_r[30:0], ~diff[32]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = neg_q_r ? (32'd0 - quo_r) : quo_r;
  assign rsp.r    = neg_r_r ? (32'd0 - rem_r) : rem_r;

endmodule

// ===== src/msic_rf.sv =====
// Register file: one write port, two registered read ports, reset values via valid bits.
module msic_rf #(
  parameter int MEM_WORDS = msic_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  input  logic [4:0]  ra_a,
  input  logic [4:0]  ra_b,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b
);

  localparam logic [31:0] SP_RST = 32'(MEM_WORDS * 4);

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] qa_r, qb_r;
  logic        va_r, vb_r;
  logic [4:0]  aa_r, ab_r;

  function automatic logic [31:0] rst_val(input logic [4:0] i);
    if (i == msic_pkg::REG_SP)      rst_val = SP_RST;
    else if (i == msic_pkg::REG_RA) rst_val = msic_pkg::RET_ADDR_RST;
    else                            rst_val = '0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && wa != 5'd0) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && wa != 5'd0) mem[wa] <= wd;
    qa_r <= mem[ra_a];
    qb_r <= mem[ra_b];
    va_r <= vld_r[ra_a];
    vb_r <= vld_r[ra_b];
    aa_r <= ra_a;
    ab_r <= ra_b;
  end

  assign rd_a = va_r ? qa_r : rst_val(aa_r);
  assign rd_b = vb_r ? qb_r : rst_val(ab_r);

endmodule

// ===== src/mips_subset_instruction_core.sv =====
// Top level of the MIPS subset instruction core: sequencer, memory, HI/LO and PC.
//
// Channels: in_* carries one request per transfer (in_tuser = req_type), out_*
// returns exactly one status result per request, cfg_* writes the return,
// input and output address registers (cfg_ready is always high).
// Requests are handled one at a time. Steps from input transfer to result
// valid, with registered program memory and registered register reads:
//   load word / write register / execute while halted: result step only
//   plain instruction: fetch and register read, execute, result
//   lw from memory, lis, mult/multu: plus a memory read or product step
//   div/divu: plus a divider wait (one quotient bit per cycle in the divider)
// The result waits in an output register; a new request is taken while it
// waits, and the sequencer only holds in its last step if the previous result
// has still not been taken.
// Reset (rst_n low, synchronous): PC, HI, LO, halt flag and error code clear,
// registers read zero except r30 = MEM_WORDS*4 and r31 = the reset return
// address; configuration returns to its reset values. Memory content is
// undefined until loaded.
module mips_subset_instruction_core #(
  parameter int MEM_WORDS = msic_pkg::MEM_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // word_address[11:0], reg_index[16:12], data_word[48:17], console_value[80:49]
  input  logic [msic_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type[1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pc_value[31:0], halted[32], error_code[35:33], out_valid[36],
  // out_char[44:37], console_used[45]
  output logic [msic_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [31:0] MW32 = 32'(MEM_WORDS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_MEMRD = 7'b0001000,
    S_MULW  = 7'b0010000,
    S_DIVW  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;
  logic [31:0] pc_r, pc_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic        stop_r, stop_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] ir_r, ir_nxt, cv_r, cv_nxt;
  logic [4:0]  dst_r, dst_nxt;
  logic        ov_r, ov_nxt, cu_r, cu_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [63:0] prod_r;
  logic [31:0] ret_r, ina_r, outa_r;
  logic        o_vld_r, o_vld_nxt;
  logic [msic_pkg::OUT_DATA_W-1:0] o_data_r, o_data_nxt;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd, a, b;

  msic_pkg::div_req_t div_req;
  msic_pkg::div_rsp_t div_rsp;

  logic        in_fire;
  logic [11:0] in_wa;
  logic [4:0]  in_ri;
  logic [31:0] in_dw, in_cv;
  logic [5:0]  op, funct;
  logic [4:0]  rt, rd;
  logic [31:0] imm, pc1, ea;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  assign in_fire   = in_tvalid & in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_wa = in_tdata[11:0];
  assign in_ri = in_tdata[16:12];
  assign in_dw = in_tdata[48:17];
  assign in_cv = in_tdata[80:49];

  assign op    = ir_r[31:26];
  assign rt    = ir_r[20:16];
  assign rd    = ir_r[15:11];
  assign funct = ir_r[5:0];
  assign imm   = {{16{ir_r[15]}}, ir_r[15:0]};
  assign pc1   = pc_r + 32'd1;
  assign ea    = a + {{2{imm[31]}}, imm[31:2]};

  assign ma = {(funct == msic_pkg::F_MULT) & a[31], a};
  assign mb = {(funct == msic_pkg::F_MULT) & b[31], b};
  assign mp = ma * mb;

  // register reads are issued from the fetched word, data arrives in S_EXEC
  msic_rf #(.MEM_WORDS(MEM_WORDS)) u_rf (
    .clk(clk), .rst_n(rst_n), .we(rf_we), .wa(rf_wa), .wd(rf_wd),
    .ra_a(mem_q[25:21]), .ra_b(mem_q[20:16]), .rd_a(a), .rd_b(b)
  );

  msic_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_comb begin
    st_nxt = st_r;  pc_nxt = pc_r;  hi_nxt = hi_r;  lo_nxt = lo_r;
    stop_nxt = stop_r;  err_nxt = err_r;  ir_nxt = ir_r;  cv_nxt = cv_r;
    dst_nxt = dst_r;  ov_nxt = ov_r;  cu_nxt = cu_r;  ch_nxt = ch_r;
    o_vld_nxt = o_vld_r & ~out_tready;
    o_data_nxt = o_data_r;
    mem_we = 1'b0;  mem_wa = pc_r[AW-1:0];  mem_wd = b;  mem_ra = pc_r[AW-1:0];
    rf_we = 1'b0;  rf_wa = rd;  rf_wd = '0;
    div_req.start = 1'b0;
    div_req.sgn   = (funct == msic_pkg::F_DIV);
    div_req.a     = a;
    div_req.b     = b;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          ov_nxt = 1'b0;  cu_nxt = 1'b0;  ch_nxt = '0;  cv_nxt = in_cv;
          st_nxt = S_FIN;
          unique case (in_tuser)
            msic_pkg::REQ_LOAD: begin
              if ({20'd0, in_wa} < MW32) begin
                mem_we = 1'b1;
                mem_wa = AW'({20'd0, in_wa});
                mem_wd = in_dw;
              end
            end
            msic_pkg::REQ_WREG: begin
              rf_we = 1'b1;  rf_wa = in_ri;  rf_wd = in_dw;
            end
            msic_pkg::REQ_EXEC: begin
              if (!stop_r) begin
                if (pc_r >= MW32) begin
                  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_RANGE;
                end else begin
                  st_nxt = S_FETCH;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        ir_nxt = mem_q;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_FIN;
        pc_nxt = pc1;
        unique case (op)
          msic_pkg::OP_RTYPE: begin
            unique case (funct)
              msic_pkg::F_ADD:  begin rf_we = 1'b1; rf_wd = a + b; end
              msic_pkg::F_SUB:  begin rf_we = 1'b1; rf_wd = a - b; end
              msic_pkg::F_MFHI: begin rf_we = 1'b1; rf_wd = hi_r; end
              msic_pkg::F_MFLO: begin rf_we = 1'b1; rf_wd = lo_r; end
              msic_pkg::F_SLT: begin
                rf_we = 1'b1;
                rf_wd = {31'd0, ((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000))};
              end
              msic_pkg::F_SLTU: begin rf_we = 1'b1; rf_wd = {31'd0, a < b}; end
              msic_pkg::F_MULT, msic_pkg::F_MULTU: st_nxt = S_MULW;
              msic_pkg::F_DIV, msic_pkg::F_DIVU: begin
                if (b == 32'd0) begin
                  pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                  st_nxt = S_DIVW;
                end
              end
              msic_pkg::F_LIS: begin
                if (pc_r >= MW32 - 32'd1) begin
                  pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_RANGE;
                end else begin
                  mem_ra = pc1[AW-1:0];
                  dst_nxt = rd;
                  pc_nxt = pc_r + 32'd2;
                  st_nxt = S_MEMRD;
                end
              end
              msic_pkg::F_JR: begin
                pc_nxt = a;
                if (a == ret_r) stop_nxt = 1'b1;
              end
              msic_pkg::F_JALR: begin
                rf_we = 1'b1;  rf_wa = msic_pkg::REG_RA;  rf_wd = pc1;
                pc_nxt = a;
                if (a == ret_r) stop_nxt = 1'b1;
              end
              default: begin
                pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_OPCODE;
              end
            endcase
          end
          msic_pkg::OP_LW, msic_pkg::OP_SW: begin
            priority if (imm[1:0] != 2'd0) begin
              pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_ALIGN;
            end else if (op == msic_pkg::OP_LW && ea == ina_r) begin
              rf_we = 1'b1;  rf_wa = rt;  rf_wd = cv_r;  cu_nxt = 1'b1;
            end else if (op == msic_pkg::OP_SW && ea == outa_r) begin
              ov_nxt = 1'b1;  ch_nxt = b[7:0];
            end else if (ea >= MW32) begin
              pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_RANGE;
            end else if (op == msic_pkg::OP_LW) begin
              mem_ra = ea[AW-1:0];
              dst_nxt = rt;
              st_nxt = S_MEMRD;
            end else begin
              mem_we = 1'b1;  mem_wa = ea[AW-1:0];  mem_wd = b;
            end
          end
          msic_pkg::OP_BEQ: if (a == b) pc_nxt = pc1 + imm;
          msic_pkg::OP_BNE: if (a != b) pc_nxt = pc1 + imm;
          default: begin
            pc_nxt = pc_r;  stop_nxt = 1'b1;  err_nxt = msic_pkg::ERR_OPCODE;
          end
        endcase
      end
      S_MEMRD: begin
        rf_we = 1'b1;  rf_wa = dst_r;  rf_wd = mem_q;
        st_nxt = S_FIN;
      end
      S_MULW: begin
        hi_nxt = prod_r[63:32];  lo_nxt = prod_r[31:0];
        st_nxt = S_FIN;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          hi_nxt = div_rsp.r;  lo_nxt = div_rsp.q;
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!o_vld_r || out_tready) begin
          o_vld_nxt  = 1'b1;
          o_data_nxt = {2'd0, cu_r, ch_r, ov_r, err_r, stop_r, pc_r};
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pc_r    <= '0;
      hi_r    <= '0;
      lo_r    <= '0;
      stop_r  <= 1'b0;
      err_r   <= msic_pkg::ERR_NONE;
      o_vld_r <= 1'b0;
      ret_r   <= msic_pkg::RET_ADDR_RST;
      ina_r   <= msic_pkg::IN_ADDR_RST;
      outa_r  <= msic_pkg::OUT_ADDR_RST;
    end else begin
      st_r    <= st_nxt;
      pc_r    <= pc_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      stop_r  <= stop_nxt;
      err_r   <= err_nxt;
      o_vld_r <= o_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          msic_pkg::CFG_RET: ret_r  <= cfg_data;
          msic_pkg::CFG_IN:  ina_r  <= cfg_data;
          msic_pkg::CFG_OUT: outa_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ir_r     <= ir_nxt;
    cv_r     <= cv_nxt;
    dst_r    <= dst_nxt;
    ov_r     <= ov_nxt;
    cu_r     <= cu_nxt;
    ch_r     <= ch_nxt;
    o_data_r <= o_data_nxt;
    if (st_r == S_EXEC) prod_r <= mp[63:0];
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

endmodule

// ===== test/msic_checker.sv =====
// Checker for the MIPS subset core: predicts each status result and compares it.
module msic_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [msic_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [msic_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  output int                              fail_count,
  output int                              status_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // packed from the MSB down, so pc lands in the low bits like out_tdata
  typedef struct packed {
    logic        console_used;
    logic [7:0]  chr;
    logic        chr_valid;
    logic [2:0]  err;
    logic        halted;
    logic [31:0] pc;
  } status_t;

  logic [31:0] ret_addr, in_addr, out_addr;
  logic [31:0] gpr [32];
  logic [31:0] hi, lo, pc;
  logic [31:0] mem [msic_pkg::MEM_WORDS_DEF];
  logic        stop;
  logic [2:0]  err;
  status_t     status_q[$];

  function automatic void wr_gpr(logic [4:0] r, logic [31:0] v);
    if (r != 5'd0) gpr[r] = v;
  endfunction

  function automatic void halt_with(logic [2:0] code);
    stop = 1'b1;
    err = code;
  endfunction

  // one instruction; updates state and the character/console fields of s
  function automatic void run_instr(logic [31:0] console, inout status_t s);
    logic [31:0] ins, a, b, imm, ea, q, r, ua, ub;
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd;
    logic [63:0] p;
    logic        jumped;
    jumped = 1'b0;
    if (pc >= msic_pkg::MEM_WORDS_DEF) begin
      halt_with(msic_pkg::ERR_RANGE);
      return;
    end
    ins = mem[pc];
    op = ins[31:26];
    fn = ins[5:0];
    rt = ins[20:16];
    rd = ins[15:11];
    a = gpr[ins[25:21]];
    b = gpr[rt];
    imm = {{16{ins[15]}}, ins[15:0]};
    case (op)
      msic_pkg::OP_RTYPE: begin
        case (fn)
          msic_pkg::F_ADD: wr_gpr(rd, a + b);
          msic_pkg::F_SUB: wr_gpr(rd, a - b);
          msic_pkg::F_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            {hi, lo} = p;
          end
          msic_pkg::F_MULTU: begin
            p = {32'd0, a} * {32'd0, b};
            {hi, lo} = p;
          end
          msic_pkg::F_DIV: begin
            if (b == 0) begin
              halt_with(msic_pkg::ERR_DIVZERO);
              return;
            end
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            r = ua % ub;
            lo = (a[31] != b[31]) ? -q : q;
            hi = a[31] ? -r : r;
          end
          msic_pkg::F_DIVU: begin
            if (b == 0) begin
              halt_with(msic_pkg::ERR_DIVZERO);
              return;
            end
            lo = a / b;
            hi = a % b;
          end
          msic_pkg::F_MFHI: wr_gpr(rd, hi);
          msic_pkg::F_MFLO: wr_gpr(rd, lo);
          msic_pkg::F_LIS: begin
            if (pc >= msic_pkg::MEM_WORDS_DEF - 1) begin
              halt_with(msic_pkg::ERR_RANGE);
              return;
            end
            wr_gpr(rd, mem[pc + 1]);
            pc = pc + 1;
          end
          msic_pkg::F_SLT: wr_gpr(rd, {31'd0, $signed(a) < $signed(b)});
          msic_pkg::F_SLTU: wr_gpr(rd, {31'd0, a < b});
          msic_pkg::F_JR: begin
            pc = a;
            if (a == ret_addr) stop = 1'b1;
            jumped = 1'b1;
          end
          msic_pkg::F_JALR: begin
            wr_gpr(msic_pkg::REG_RA, pc + 1);
            pc = a;
            if (a == ret_addr) stop = 1'b1;
            jumped = 1'b1;
          end
          default: begin
            halt_with(msic_pkg::ERR_OPCODE);
            return;
          end
        endcase
      end
      msic_pkg::OP_LW, msic_pkg::OP_SW: begin
        if (imm[1:0] != 2'b00) begin
          halt_with(msic_pkg::ERR_ALIGN);
          return;
        end
        ea = a + {{2{imm[31]}}, imm[31:2]};
        if (op == msic_pkg::OP_LW && ea == in_addr) begin
          wr_gpr(rt, console);
          s.console_used = 1'b1;
        end else if (op == msic_pkg::OP_SW && ea == out_addr) begin
          s.chr_valid = 1'b1;
          s.chr = b[7:0];
        end else if (ea >= msic_pkg::MEM_WORDS_DEF) begin
          halt_with(msic_pkg::ERR_RANGE);
          return;
        end else if (op == msic_pkg::OP_LW) begin
          wr_gpr(rt, mem[ea]);
        end else begin
          mem[ea] = b;
        end
      end
      msic_pkg::OP_BEQ: if (a == b) pc = pc + imm;
      msic_pkg::OP_BNE: if (a != b) pc = pc + imm;
      default: begin
        halt_with(msic_pkg::ERR_OPCODE);
        return;
      end
    endcase
    if (!jumped) pc = pc + 1;
  endfunction

  function automatic status_t predict_status(logic [1:0] kind,
                                             logic [msic_pkg::IN_DATA_W-1:0] d);
    status_t s;
    s = '0;
    case (kind)
      msic_pkg::REQ_LOAD: mem[d[11:0]] = d[48:17];
      msic_pkg::REQ_WREG: wr_gpr(d[16:12], d[48:17]);
      msic_pkg::REQ_EXEC: if (!stop) run_instr(d[80:49], s);
      default: ;
    endcase
    s.pc = pc;
    s.halted = stop;
    s.err = err;
    return s;
  endfunction

  task automatic compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t got, want;
    if (!rst_n) begin
      ret_addr <= msic_pkg::RET_ADDR_RST;
      in_addr <= msic_pkg::IN_ADDR_RST;
      out_addr <= msic_pkg::OUT_ADDR_RST;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      gpr[msic_pkg::REG_SP] = 32'(msic_pkg::MEM_WORDS_DEF * 4);
      gpr[msic_pkg::REG_RA] = msic_pkg::RET_ADDR_RST;
      hi = '0;
      lo = '0;
      pc = '0;
      stop = 1'b0;
      err = msic_pkg::ERR_NONE;
      status_q.delete();
      fail_count = 0;
      status_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msic_pkg::CFG_RET: ret_addr <= cfg_data;
          msic_pkg::CFG_IN:  in_addr <= cfg_data;
          msic_pkg::CFG_OUT: out_addr <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) status_q.push_back(predict_status(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[45:0];
        if (status_q.size() == 0) begin
          $error("status result with none expected: %0h", got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          compare("pc_value", want.pc, got.pc);
          compare("halted", 32'(want.halted), 32'(got.halted));
          compare("error_code", 32'(want.err), 32'(got.err));
          compare("out_valid", 32'(want.chr_valid), 32'(got.chr_valid));
          compare("out_char", 32'(want.chr), 32'(got.chr));
          compare("console_used", 32'(want.console_used), 32'(got.console_used));
        end
      end
      status_pending = status_q.size();
    end
  end
endmodule

// ===== test/mips_subset_instruction_core_tb.sv =====
// Testbench top: drives programs and requests into the core, gives the verdict.
module mips_subset_instruction_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DMEM = 3000;   // data area base; programs live below
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready, out_tvalid, out_tready = 1'b0;
  logic [msic_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic [msic_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, status_pending;
  int send_idle = 0, recv_stall = 0;
  int hold_off = 0;
  bit hold_start = 1'b0;
  bit hold_used = 1'b0;

  always #10 clk = ~clk;

  mips_subset_instruction_core dut (.*);

  msic_checker chk (.*);

  // receiver side with random stalls and a single long hold-off
  always @(posedge clk) begin
    if (hold_start && !hold_used) begin
      hold_used <= 1'b1;
      hold_off <= 300;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #30ms;
    $display("mips_subset_instruction_core: mismatch");
    $finish;
  end

  // valid stays up after a transfer; the next send or drain replaces or drops it
  task automatic send(logic [1:0] kind, logic [11:0] wa, logic [4:0] ri, logic [31:0] dw,
                      logic [31:0] con);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, con, dw, ri, wa};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic put_word(int a, logic [31:0] w);
    send(msic_pkg::REQ_LOAD, a[11:0], 5'($urandom), w, $urandom);
  endtask

  task automatic set_reg(logic [4:0] r, logic [31:0] v);
    send(msic_pkg::REQ_WREG, 12'($urandom), r, v, $urandom);
  endtask

  task automatic step(logic [31:0] con);
    send(msic_pkg::REQ_EXEC, 12'($urandom), 5'($urandom), $urandom, con);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // instruction encoders
  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn);
    return {msic_pkg::OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // random instruction; keeps data accesses in written memory
  function automatic logic [31:0] rand_instr();
    logic [5:0] fns [13] = '{msic_pkg::F_ADD, msic_pkg::F_SUB, msic_pkg::F_MULT,
                             msic_pkg::F_MULTU, msic_pkg::F_DIV, msic_pkg::F_DIVU,
                             msic_pkg::F_MFHI, msic_pkg::F_MFLO, msic_pkg::F_SLT,
                             msic_pkg::F_SLTU, msic_pkg::F_ADD, msic_pkg::F_SUB,
                             msic_pkg::F_SLT};
    logic [4:0] rs, rt, rd;
    int k;
    rs = 5'($urandom_range(1, 9));
    rt = 5'($urandom_range(0, 9));
    rd = 5'($urandom_range(0, 9));
    k = $urandom_range(99);
    if (k < 55) return rtype(rs, rt, rd, fns[$urandom_range(12)]);
    // addresses via r20 (data base), r21 (console), r22 (char out)
    if (k < 65) return itype(msic_pkg::OP_LW, 5'd20, rt, 16'($urandom_range(0, 15) * 4));
    if (k < 72) return itype(msic_pkg::OP_SW, 5'd20, rt, 16'($urandom_range(0, 15) * 4));
    if (k < 78) return itype(msic_pkg::OP_LW, 5'd21, rt, 16'd0);
    if (k < 84) return itype(msic_pkg::OP_SW, 5'd22, rt, 16'd0);
    if (k < 90) return itype(msic_pkg::OP_BEQ, rs, rt, 16'($urandom_range(0, 2)));
    if (k < 96) return itype(msic_pkg::OP_BNE, rs, rt, 16'($urandom_range(0, 2)));
    return 32'($urandom);  // noise: mostly bad opcodes
  endfunction

  // load a program at 0 and run it; counts the requests sent
  task automatic run_program(int len, int execs, inout int items);
    for (int i = 0; i < len; i++) begin
      put_word(i, rand_instr());
      items++;
    end
    // trailing words so a fetch just past the body is defined; end with jr to r31
    put_word(len, rtype(5'd31, 5'd0, 5'd0, msic_pkg::F_JR));
    put_word(len + 1, rtype(5'd31, 5'd0, 5'd0, msic_pkg::F_JR));
    put_word(len + 2, rtype(5'd31, 5'd0, 5'd0, msic_pkg::F_JR));
    items += 3;
    for (int i = 0; i < execs; i++) begin
      step($urandom);
      items++;
    end
  endtask

  initial begin
    int items, len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // data area fully initialized so random lw/sw never see unwritten words
    for (int i = 0; i < 16; i++) put_word(DMEM + i, $urandom);
    put_word(4095, 32'hFFFF_FFFF);
    put_word(12'hFFF + 1, 32'h1234);  // wraps in 12 bits: word 0 gets overwritten next
    // directed: registers and every operation
    set_reg(5'd0, 32'hDEAD_BEEF);
    set_reg(5'd1, 32'h8000_0000);
    set_reg(5'd2, 32'hFFFF_FFFF);
    set_reg(5'd3, 32'd7);
    set_reg(5'd20, DMEM);
    set_reg(5'd21, msic_pkg::IN_ADDR_RST);
    set_reg(5'd22, msic_pkg::OUT_ADDR_RST);
    put_word(0, rtype(5'd1, 5'd2, 5'd4, msic_pkg::F_ADD));
    put_word(1, rtype(5'd1, 5'd3, 5'd5, msic_pkg::F_SUB));
    put_word(2, rtype(5'd1, 5'd2, 5'd0, msic_pkg::F_DIV));   // most negative / -1
    put_word(3, rtype(5'd0, 5'd0, 5'd6, msic_pkg::F_MFHI));
    put_word(4, rtype(5'd0, 5'd0, 5'd7, msic_pkg::F_MFLO));
    put_word(5, rtype(5'd1, 5'd2, 5'd0, msic_pkg::F_MULT));
    put_word(6, rtype(5'd1, 5'd2, 5'd0, msic_pkg::F_MULTU));
    put_word(7, rtype(5'd2, 5'd3, 5'd0, msic_pkg::F_DIVU));
    put_word(8, rtype(5'd0, 5'd0, 5'd8, msic_pkg::F_LIS));
    put_word(9, 32'hCAFE_F00D);
    put_word(10, rtype(5'd1, 5'd3, 5'd9, msic_pkg::F_SLT));
    put_word(11, rtype(5'd1, 5'd3, 5'd9, msic_pkg::F_SLTU));
    put_word(12, itype(msic_pkg::OP_LW, 5'd21, 5'd0, 16'd0));  // console into r0
    put_word(13, itype(msic_pkg::OP_LW, 5'd21, 5'd10, 16'd0));
    put_word(14, itype(msic_pkg::OP_SW, 5'd22, 5'd10, 16'd0));
    put_word(15, itype(msic_pkg::OP_SW, 5'd20, 5'd2, 16'hFFFC)); // DMEM-1
    put_word(16, itype(msic_pkg::OP_LW, 5'd20, 5'd11, 16'hFFFC));
    put_word(17, itype(msic_pkg::OP_BEQ, 5'd3, 5'd3, 16'd1));
    put_word(18, 32'hFC00_0000);                    // skipped
    put_word(19, itype(msic_pkg::OP_BNE, 5'd3, 5'd3, 16'd5));
    put_word(20, itype(msic_pkg::OP_BNE, 5'd3, 5'd0, 16'd0));
    set_reg(5'd12, 32'd23);
    put_word(21, rtype(5'd12, 5'd0, 5'd0, msic_pkg::F_JALR));
    put_word(23, rtype(5'd12, 5'd0, 5'd0, msic_pkg::F_JR));   // jr to itself
    put_word(DMEM - 1, 32'd0);
    for (int i = 0; i < 23; i++) step(32'h8000_0000 ^ i);
    drain();
    // make word 23 the return address so the next jr halts the core
    write_cfg(msic_pkg::CFG_RET, 32'd23);
    step(32'd1);  // jr to 23 = return address: halt
    step(32'd2);  // executes while halted
    drain();
    // the core stays halted from here; keep exercising loads, writes and config
    items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        3: begin send_idle = 21; recv_stall = 21; end
        default: begin send_idle = 0; recv_stall = 0; hold_start = 1'b1; end
      endcase
      write_cfg(msic_pkg::CFG_RET, ph == 0 ? 32'd0 : 32'($urandom));
      write_cfg(msic_pkg::CFG_IN, ph == 1 ? 32'hFFFF_FFFF : 32'($urandom));
      write_cfg(msic_pkg::CFG_OUT, ph == 2 ? 32'd0 : 32'($urandom));
      len = $urandom_range(4, 40);
      run_program(len, 40, items);
      for (int i = 0; i < 50; i++) begin
        set_reg(5'($urandom), $urandom);
        put_word($urandom_range(0, DMEM - 1), $urandom);
        items += 2;
      end
      for (int i = 0; i < 10; i++) begin
        send(REQ_UNUSED, 12'($urandom), 5'($urandom), $urandom, $urandom);
        items++;
      end
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (fail_count == 0) begin
      $display("mips_subset_instruction_core: match");
    end else begin
      $display("mips_subset_instruction_core: mismatch");
    end
    $finish;
  end
endmodule

// ===== mips_subset_instruction_core.f =====
src/msic_pkg.sv
src/msic_div.sv
src/msic_rf.sv
src/mips_subset_instruction_core.sv
test/msic_checker.sv
test/mips_subset_instruction_core_tb.sv
